// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and helpers for the integer to ASCII converter.
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MODE_W          = 2;
    localparam int CHAR_W          = 7;

    // mode codes on the input word
    localparam logic [MODE_W-1:0] MODE_DEC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BIN = 2'd2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_BIN
    } radix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic sign;
        logic emit;
    } itoa_cmd_t;

    typedef struct packed {
        logic load_dec;
        logic neg;
        logic cnt_one;
        logic out_free;
    } itoa_sts_t;

    // unused mode code falls back to decimal
    function automatic radix_t decode_mode(input logic [MODE_W-1:0] mode);
        radix_t r;
        case (mode)
            MODE_HEX: r = RADIX_HEX;
            MODE_BIN: r = RADIX_BIN;
            default:  r = RADIX_DEC;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = ASCII_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

// ===== rtl/itoa_in_if.sv =====
// Input channel: integer value and radix mode.
interface itoa_in_if #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [itoa_pkg::MODE_W-1:0]   mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink   (input valid, input value, input mode, output ready);
endinterface

// ===== rtl/itoa_out_if.sv =====
// Output channel: one ASCII character per word with a last flag.
interface itoa_out_if;
    logic                        valid;
    logic                        ready;
    logic [itoa_pkg::CHAR_W-1:0] text_char;
    logic                        last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface

// ===== rtl/itoa_ctrl.sv =====
// Sequencing state machine for the converter.
module itoa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itoa_pkg::itoa_sts_t sts,
    output itoa_pkg::itoa_cmd_t cmd
);

    itoa_pkg::state_t state_reg;
    itoa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.load_dec ? itoa_pkg::ST_CONV : itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_CONV:
            begin
                if (sts.cnt_one)
                begin
                    state_next = sts.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_EMIT:
            begin
                if (sts.out_free && sts.cnt_one)
                begin
                    state_next = itoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            itoa_pkg::ST_CONV:
            begin
                cmd.conv = 1'b1;
            end
            itoa_pkg::ST_SIGN:
            begin
                cmd.sign = sts.out_free;
            end
            itoa_pkg::ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/itoa_dp.sv =====
// Datapath: magnitude, binary to BCD shifter, digit scan and output register.
module itoa_dp #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic [itoa_pkg::MODE_W-1:0]   mode,
    input  itoa_pkg::itoa_cmd_t           cmd,
    output itoa_pkg::itoa_sts_t           sts,
    itoa_out_if.source                    dout
);

    localparam int HDIG = (VALUE_WIDTH + 3) / 4;
    localparam int PW   = 4 * HDIG;
    // decimal digits of 2^VALUE_WIDTH - 1
    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BW   = 4 * NDIG;
    localparam int CMAX = (PW > NDIG) ? PW : NDIG;
    localparam int CW   = $clog2(CMAX + 1);

    logic [PW-1:0]                 pad_reg;
    logic [PW-1:0]                 pad_next;
    logic [BW-1:0]                 bcd_reg;
    logic [BW-1:0]                 bcd_next;
    logic [BW-1:0]                 bcd_adj;
    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 cnt_next;
    logic                          neg_reg;
    logic                          neg_next;
    itoa_pkg::radix_t              radix_reg;
    itoa_pkg::radix_t              radix_next;
    logic                          started_reg;
    logic                          started_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [itoa_pkg::CHAR_W-1:0]   char_reg;
    logic [itoa_pkg::CHAR_W-1:0]   char_next;
    logic                          last_reg;
    logic                          last_next;

    itoa_pkg::radix_t              in_radix;
    logic                          in_neg;
    logic [VALUE_WIDTH-1:0]        in_mag;
    logic [3:0]                    digit;
    logic                          skip;
    logic                          produce;

    assign in_radix = itoa_pkg::decode_mode(mode);
    assign in_neg   = (in_radix == itoa_pkg::RADIX_DEC) && value[VALUE_WIDTH-1];
    assign in_mag   = in_neg ? (~value + 1'b1) : value;

    // add-3 correction on every BCD digit before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        case (radix_reg)
            itoa_pkg::RADIX_HEX: digit = pad_reg[PW-1 -: 4];
            itoa_pkg::RADIX_BIN: digit = {3'b000, pad_reg[PW-1]};
            default:             digit = bcd_reg[BW-1 -: 4];
        endcase
    end

    // leading zeros are dropped, but the final digit always goes out
    assign skip    = (digit == 4'd0) && !started_reg && (cnt_reg != CW'(1));
    assign produce = cmd.sign || (cmd.emit && !skip);

    always_comb
    begin
        pad_next     = pad_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        radix_next   = radix_reg;
        started_next = started_reg;
        char_next    = char_reg;
        last_next    = last_reg;

        if (cmd.load)
        begin
            pad_next     = PW'(in_mag);
            bcd_next     = '0;
            neg_next     = in_neg;
            radix_next   = in_radix;
            started_next = 1'b0;
            cnt_next     = (in_radix == itoa_pkg::RADIX_HEX) ? CW'(HDIG) : CW'(PW);
        end
        else if (cmd.conv)
        begin
            bcd_next = {bcd_adj[BW-2:0], pad_reg[PW-1]};
            pad_next = pad_reg << 1;
            cnt_next = (cnt_reg == CW'(1)) ? CW'(NDIG) : (cnt_reg - 1'b1);
        end
        else if (cmd.sign)
        begin
            char_next = itoa_pkg::ASCII_MINUS;
            last_next = 1'b0;
        end
        else if (cmd.emit)
        begin
            case (radix_reg)
                itoa_pkg::RADIX_HEX: pad_next = pad_reg << 4;
                itoa_pkg::RADIX_BIN: pad_next = pad_reg << 1;
                default:             bcd_next = bcd_reg << 4;
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (!skip)
            begin
                started_next = 1'b1;
                char_next    = itoa_pkg::digit_to_ascii(digit);
                last_next    = (cnt_reg == CW'(1));
            end
        end
    end

    assign out_valid_next = produce ? 1'b1 : (dout.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_reg   <= pad_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign dout.valid     = out_valid_reg;
    assign dout.text_char = char_reg;
    assign dout.last      = last_reg;

    assign sts.load_dec = (in_radix == itoa_pkg::RADIX_DEC);
    assign sts.neg      = neg_reg;
    assign sts.cnt_one  = (cnt_reg == CW'(1));
    assign sts.out_free = !out_valid_reg || dout.ready;

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.conv, cmd.sign, cmd.emit}))
        else $error("more than one datapath command at once");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.text_char == itoa_pkg::ASCII_MINUS) |-> !dout.last)
        else $error("minus sign flagged as last character");

    // checked as the character is produced; the register may still hold the
    // previous number's last character once the next word is loaded
    a_dec_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && radix_reg == itoa_pkg::RADIX_DEC) |->
        (char_next == itoa_pkg::ASCII_MINUS ||
         (char_next >= itoa_pkg::ASCII_ZERO &&
          char_next <= itoa_pkg::ASCII_NINE)))
        else $error("non-decimal character in decimal output");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        produce |-> (!out_valid_reg || dout.ready))
        else $error("output word overwritten before it was taken");

endmodule

// ===== rtl/int_to_ascii_dec_hex_bin.sv =====
// Integer to ASCII text converter (decimal, hexadecimal, binary), top level.
// Decimal words first run the shift-add-3 BCD loop over every bit of the zero-padded magnitude
//   before the first character; hex and binary words go straight to emitting.
// Throughput: one character per cycle at most, while the output register is free; leading zero
//   digits are scanned at one a cycle, under the same condition, and give no character.
// The next word is taken while the last character still waits in the output register.
// Reset (rst_n, async, active low) returns to idle and drops any pending character.
module int_to_ascii_dec_hex_bin #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    itoa_in_if.sink     din,
    itoa_out_if.source  dout
);

    itoa_pkg::itoa_cmd_t cmd;
    itoa_pkg::itoa_sts_t sts;

    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .value (din.value),
        .mode  (din.mode),
        .cmd   (cmd),
        .sts   (sts),
        .dout  (dout)
    );

endmodule

// ===== test/itoa_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the integer to ASCII converter: predicts every character and checks the output.
module itoa_scoreboard #(
    parameter int VW = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    itoa_in_if   din,
    itoa_out_if  dout,
    output int   pending,
    output int   fails
);

    typedef struct packed {
        logic [itoa_pkg::CHAR_W-1:0] text_char;
        logic                        last;
    } glyph_t;

    glyph_t text_due[$];
    glyph_t due;

    function automatic logic [itoa_pkg::CHAR_W-1:0] glyph_of(input logic [3:0] d);
        return (d < 4'd10) ? itoa_pkg::ASCII_ZERO + itoa_pkg::CHAR_W'(d)
                           : itoa_pkg::ASCII_A + itoa_pkg::CHAR_W'(d - 4'd10);
    endfunction

    // Text of one number, most significant digit first, appended to the due list
    function automatic void predict_text(input logic [VW-1:0] v,
                                         input logic [itoa_pkg::MODE_W-1:0] m);
        logic [itoa_pkg::CHAR_W-1:0] digits[$];
        logic [VW-1:0]               mag;
        int                          shift;
        glyph_t                      g;
        shift = (m == itoa_pkg::MODE_HEX) ? 4 : 1;
        if (m == itoa_pkg::MODE_HEX || m == itoa_pkg::MODE_BIN)
        begin
            mag = v;
            do
            begin
                digits.push_front(glyph_of(4'(mag & ((1 << shift) - 1))));
                mag = mag >> shift;
            end
            while (mag != '0);
        end
        else
        begin
            // unused mode falls back to decimal; the negation wraps, so the most
            // negative value comes out as its true magnitude
            mag = v[VW-1] ? -v : v;
            do
            begin
                digits.push_front(glyph_of(4'(mag % 10)));
                mag = mag / 10;
            end
            while (mag != '0);
            if (v[VW-1])
            begin
                digits.push_front(itoa_pkg::ASCII_MINUS);
            end
        end
        foreach (digits[i])
        begin
            g.text_char = digits[i];
            g.last      = (i == digits.size() - 1);
            text_due.push_back(g);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din.valid && din.ready)
            begin
                predict_text(din.value, din.mode);
            end
            if (dout.valid && dout.ready)
            begin
                if (text_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: word with nothing due: expected none, actual char %h last %0b",
                             $time, dout.text_char, dout.last);
                end
                else
                begin
                    due = text_due.pop_front();
                    if (dout.text_char !== due.text_char)
                    begin
                        fails++;
                        $display("%0t: text_char mismatch: expected %h, actual %h",
                                 $time, due.text_char, dout.text_char);
                    end
                    if (dout.last !== due.last)
                    begin
                        fails++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, due.last, dout.last);
                    end
                end
            end
            pending <= text_due.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, stimulus, output stalls and verdict.
module testbench;

    localparam int                          VW          = 32;
    localparam logic [itoa_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;
    localparam int                          QUIET_LIMIT = 3000;
    localparam int                          HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    int   pending;
    int   fails;

    // idling switches per phase, and a request for one long output hold-off
    bit   src_idle;
    bit   sink_idle;
    bit   hold_out;

    itoa_in_if #(.VALUE_WIDTH(VW)) din_ch();
    itoa_out_if                    dout_ch();

    int_to_ascii_dec_hex_bin #(.VALUE_WIDTH(VW)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    itoa_scoreboard #(.VW(VW)) u_scoreboard (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_ch),
        .dout    (dout_ch),
        .pending (pending),
        .fails   (fails)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Valid is kept high across back-to-back words and only dropped before a gap
    task automatic send_word(input logic [VW-1:0] v, input logic [itoa_pkg::MODE_W-1:0] m);
        int gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            din_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_ch.valid <= 1'b1;
        din_ch.value <= v;
        din_ch.mode  <= m;
        @(posedge clk);
        while (!din_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        din_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    function automatic logic [VW-1:0] random_value();
        logic [VW-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = VW'($urandom_range(0, 20));
            1:       v = -VW'($urandom_range(1, 20));
            2:       v = VW'(10 ** $urandom_range(0, 9)) + VW'($urandom_range(0, 2)) - 1'b1;
            3:       v = VW'(1) << $urandom_range(0, VW - 1);
            4:       v = VW'($urandom_range(0, 65535));
            default: v = VW'($urandom());
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            v = -v;
        end
        return v;
    endfunction

    function automatic logic [itoa_pkg::MODE_W-1:0] random_mode();
        return ($urandom_range(0, 11) == 0) ? MODE_SPARE
                                            : itoa_pkg::MODE_W'($urandom_range(0, 2));
    endfunction

    // output side: a random stall before each word, and one long hold-off on request
    initial
    begin : sink_side
        int stall;
        dout_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_idle ? $urandom_range(0, 11) : 0;
            if (hold_out)
            begin
                hold_out = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                dout_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dout_ch.ready <= 1'b1;
            @(posedge clk);
            while (!dout_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        hold_out     = 1'b0;
        rst_n        <= 1'b0;
        din_ch.valid <= 1'b0;
        din_ch.value <= '0;
        din_ch.mode  <= itoa_pkg::MODE_DEC;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, each radix, unused mode, most negative decimal
        send_word(32'd0,          itoa_pkg::MODE_DEC);
        send_word(32'd1,          itoa_pkg::MODE_DEC);
        send_word(-32'sd1,        itoa_pkg::MODE_DEC);
        send_word(32'h7FFF_FFFF,  itoa_pkg::MODE_DEC);
        send_word(32'h8000_0000,  itoa_pkg::MODE_DEC);
        send_word(32'd10,         itoa_pkg::MODE_DEC);
        send_word(-32'sd10,       itoa_pkg::MODE_DEC);
        send_word(32'd999999999,  itoa_pkg::MODE_DEC);
        send_word(32'd1000000000, itoa_pkg::MODE_DEC);
        send_word(32'd0,          itoa_pkg::MODE_HEX);
        send_word(32'hFFFF_FFFF,  itoa_pkg::MODE_HEX);
        send_word(32'h8000_0000,  itoa_pkg::MODE_HEX);
        send_word(32'h0ABC_DEF0,  itoa_pkg::MODE_HEX);
        send_word(32'h1234_5679,  itoa_pkg::MODE_HEX);
        send_word(32'd0,          itoa_pkg::MODE_BIN);
        send_word(32'd1,          itoa_pkg::MODE_BIN);
        send_word(32'hFFFF_FFFF,  itoa_pkg::MODE_BIN);
        send_word(32'h8000_0000,  itoa_pkg::MODE_BIN);
        send_word(32'h5555_5555,  itoa_pkg::MODE_BIN);
        send_word(-32'sd123,      MODE_SPARE);
        send_word(32'h8000_0000,  MODE_SPARE);
        send_word(32'd7,          MODE_SPARE);
        wait_drained();

        // random phases with different idling, one of them with a long output hold-off
        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle  = (phase == 0) || (phase == 3);
            sink_idle = (phase == 0) || (phase == 2);
            hold_out  = (phase == 2);
            for (int n = 0; n < 35; n++)
            begin
                send_word(random_value(), random_mode());
            end
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (fails == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== int_to_ascii_dec_hex_bin.f =====
rtl/itoa_pkg.sv
rtl/itoa_in_if.sv
rtl/itoa_out_if.sv
rtl/itoa_ctrl.sv
rtl/itoa_dp.sv
rtl/int_to_ascii_dec_hex_bin.sv
test/itoa_scoreboard.sv
test/testbench.sv
